// ===== rtl/slrf_pkg.sv =====
// Shared types and constants for the streamline label ROI filter.
// No dependencies; every other file in rtl/ imports this package.
package slrf_pkg;

	localparam int MAX_TOUCH  = 8;
	localparam int MAX_FORBID = 8;
	localparam int MAX_ENDS   = 4;
	localparam int LABEL_BITS = 16;

	// Each list entry occupies a 16-bit slot in its configuration word.
	localparam int SLOT_BITS  = 16;
	localparam int SLOTS_WORD = 4;

	localparam int NUM_CELLS = (MAX_TOUCH > MAX_FORBID)
		? ((MAX_TOUCH > MAX_ENDS) ? MAX_TOUCH : MAX_ENDS)
		: ((MAX_FORBID > MAX_ENDS) ? MAX_FORBID : MAX_ENDS);

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int TCNT_W     = 4;
	localparam int FCNT_W     = 4;
	localparam int ECNT_W     = 3;
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOUCH_LO  = 4'd0,
		CFG_TOUCH_HI  = 4'd1,
		CFG_TOUCH_CNT = 4'd2,
		CFG_FORBID_LO = 4'd3,
		CFG_FORBID_HI = 4'd4,
		CFG_FORBID_CNT = 4'd5,
		CFG_END_LBL   = 4'd6,
		CFG_END_CNT   = 4'd7
	} cfg_idx_t;

	// Per-cell list entries and whether each entry is in use.
	typedef struct packed {
		logic [LABEL_BITS-1:0] t_label;
		logic [LABEL_BITS-1:0] f_label;
		logic [LABEL_BITS-1:0] e_label;
		logic                  t_act;
		logic                  f_act;
		logic                  e_act;
	} cell_cfg_t;

	// A point as it travels down the chain, with the partial results.
	typedef struct packed {
		logic [LABEL_BITS-1:0] label;
		logic                  in_image;
		logic                  first;
		logic                  last;
		logic                  t_done;
		logic                  f_done;
		logic                  e_done;
		logic [TCNT_W-1:0]     tcnt;
		logic [ECNT_W-1:0]     ecnt;
		logic                  fhit;
	} item_t;

endpackage

// ===== rtl/slrf_cfg.sv =====
// Configuration register file for the label filter: holds the three lists and counts.
// Depends on slrf_pkg; slices the list words into per-cell entries.
module slrf_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [slrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slrf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [slrf_pkg::TCNT_W-1:0]      touch_count,
	output logic [slrf_pkg::ECNT_W-1:0]      end_count,
	output slrf_pkg::cell_cfg_t [slrf_pkg::NUM_CELLS-1:0] cell_cfg
);
	import slrf_pkg::*;

	logic [CFG_DATA_W-1:0] touch_lo_q, touch_hi_q, forbid_lo_q, forbid_hi_q, end_lbl_q;
	logic [TCNT_W-1:0]     touch_cnt_q;
	logic [FCNT_W-1:0]     forbid_cnt_q;
	logic [ECNT_W-1:0]     end_cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_lo_q   <= '0;
			touch_hi_q   <= '0;
			forbid_lo_q  <= '0;
			forbid_hi_q  <= '0;
			end_lbl_q    <= '0;
			touch_cnt_q  <= '0;
			forbid_cnt_q <= '0;
			end_cnt_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TOUCH_LO:   touch_lo_q   <= cfg_data;
				CFG_TOUCH_HI:   touch_hi_q   <= cfg_data;
				CFG_TOUCH_CNT:  touch_cnt_q  <= cfg_data[TCNT_W-1:0];
				CFG_FORBID_LO:  forbid_lo_q  <= cfg_data;
				CFG_FORBID_HI:  forbid_hi_q  <= cfg_data;
				CFG_FORBID_CNT: forbid_cnt_q <= cfg_data[FCNT_W-1:0];
				CFG_END_LBL:    end_lbl_q    <= cfg_data;
				CFG_END_CNT:    end_cnt_q    <= cfg_data[ECNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign touch_count = touch_cnt_q;
	assign end_count   = end_cnt_q;

	// Entry k is in use when k is below the raw count and below the list size.
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_slice
		if (k < MAX_TOUCH) begin : g_t
			if (k < SLOTS_WORD) begin : g_lo
				assign cell_cfg[k].t_label = touch_lo_q[SLOT_BITS*k +: LABEL_BITS];
			end else begin : g_hi
				assign cell_cfg[k].t_label =
					touch_hi_q[SLOT_BITS*(k-SLOTS_WORD) +: LABEL_BITS];
			end
			assign cell_cfg[k].t_act = (TCNT_W'(k) < touch_cnt_q);
		end else begin : g_tn
			assign cell_cfg[k].t_label = '0;
			assign cell_cfg[k].t_act   = 1'b0;
		end

		if (k < MAX_FORBID) begin : g_f
			if (k < SLOTS_WORD) begin : g_lo
				assign cell_cfg[k].f_label = forbid_lo_q[SLOT_BITS*k +: LABEL_BITS];
			end else begin : g_hi
				assign cell_cfg[k].f_label =
					forbid_hi_q[SLOT_BITS*(k-SLOTS_WORD) +: LABEL_BITS];
			end
			assign cell_cfg[k].f_act = (FCNT_W'(k) < forbid_cnt_q);
		end else begin : g_fn
			assign cell_cfg[k].f_label = '0;
			assign cell_cfg[k].f_act   = 1'b0;
		end

		if (k < MAX_ENDS) begin : g_e
			assign cell_cfg[k].e_label = end_lbl_q[SLOT_BITS*k +: LABEL_BITS];
			assign cell_cfg[k].e_act   = (ECNT_W'(k) < end_cnt_q);
		end else begin : g_en
			assign cell_cfg[k].e_label = '0;
			assign cell_cfg[k].e_act   = 1'b0;
		end
	end

endmodule

// ===== rtl/slrf_cell.sv =====
// One cell of the matching chain: owns the seen bits of one touch, forbidden and
// ending entry, matches the passing point and forwards it. Depends on slrf_pkg.
module slrf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  slrf_pkg::cell_cfg_t ccfg,
	input  logic                in_valid,
	input  slrf_pkg::item_t     in_item,
	output logic                out_valid,
	output slrf_pkg::item_t     out_item
);
	import slrf_pkg::*;

	logic  t_seen_q, f_seen_q, e_seen_q;
	logic  out_valid_q;
	item_t item_q;

	logic  t_hit, f_hit, e_hit;
	logic  t_new, f_new, e_new;
	item_t nxt;

	always_comb begin
		// Only the first equal entry along the chain takes a match.
		t_hit = in_item.in_image && ccfg.t_act && !in_item.t_done
			&& (in_item.label == ccfg.t_label);
		f_hit = in_item.in_image && ccfg.f_act && !in_item.f_done
			&& (in_item.label == ccfg.f_label);
		e_hit = in_item.in_image && (in_item.first || in_item.last) && ccfg.e_act
			&& !in_item.e_done && (in_item.label == ccfg.e_label);

		// A first point abandons whatever the previous fiber left behind.
		t_new = (!in_item.first && t_seen_q) || t_hit;
		f_new = (!in_item.first && f_seen_q) || f_hit;
		e_new = (!in_item.first && e_seen_q) || e_hit;

		nxt        = in_item;
		nxt.t_done = in_item.t_done || t_hit;
		nxt.f_done = in_item.f_done || f_hit;
		nxt.e_done = in_item.e_done || e_hit;
		nxt.tcnt   = in_item.tcnt + TCNT_W'(in_item.last && t_new);
		nxt.ecnt   = in_item.ecnt + ECNT_W'(in_item.last && e_new);
		nxt.fhit   = in_item.fhit || (in_item.last && f_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_seen_q    <= 1'b0;
			f_seen_q    <= 1'b0;
			e_seen_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= in_valid;
			if (in_valid) begin
				t_seen_q <= t_new && !in_item.last;
				f_seen_q <= f_new && !in_item.last;
				e_seen_q <= e_new && !in_item.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = item_q;

	// A finished fiber leaves nothing behind in this cell.
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid && in_item.last) |=> (!t_seen_q && !f_seen_q && !e_seen_q))
		else $error("cell seen bits not cleared after last point");

	// Counts only grow as an item moves down the chain.
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid) |=> (out_item.tcnt >= $past(in_item.tcnt)
			&& out_item.ecnt >= $past(in_item.ecnt)))
		else $error("partial count decreased in cell");

	// A stalled chain keeps its seen bits.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(t_seen_q) && $stable(f_seen_q) && $stable(e_seen_q)))
		else $error("cell state changed while stalled");

endmodule

// ===== rtl/streamline_label_roi_filter_core.sv =====
// Top level of the streamline label ROI filter: config registers, a chain of
// matching cells and the result register. Depends on slrf_pkg, slrf_cfg, slrf_cell.
//
//  Channel  | Handshake                     | Payload
//  ---------+-------------------------------+--------------------------------------------
//  s_axis   | s_axis_tvalid / s_axis_tready | tdata label_value, tuser inside/first, tlast
//  m_axis   | m_axis_tvalid / m_axis_tready | tdata keep, forbidden_hit, endings_ok, count
//  cfg      | cfg_valid / cfg_ready         | cfg_index, cfg_data (64 bits)
//
// One point is taken per cycle while the chain advances. A point passes the NUM_CELLS
// cells (8 here) in turn, and the result of a fiber is then held in the result register.
// Reset clears all seen bits, the configuration and the chain valid bits at once.
// When a result waits and m_axis_tready is low, the whole chain holds and
// s_axis_tready drops; cfg writes are always taken.
module streamline_label_roi_filter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [slrf_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] label_value
	input  logic [slrf_pkg::IN_USER_W-1:0]    s_axis_tuser,  // [0] inside_req, [1] first_point
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] keep, [1] forbidden_hit, [2] endings_ok, [6:3] touched_count, [7] zero
	output logic [slrf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [slrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import slrf_pkg::*;

	logic [TCNT_W-1:0]               touch_count;
	logic [ECNT_W-1:0]               end_count;
	cell_cfg_t [NUM_CELLS-1:0]       cell_cfg;

	logic                            adv;
	logic [NUM_CELLS:0]              chain_valid;
	item_t                           chain_item [NUM_CELLS+1];

	logic                            out_valid_q;
	logic                            keep_q, fhit_q, ends_ok_q;
	logic [TCNT_W-1:0]               tcnt_q;

	item_t                           tail;
	logic                            tail_ends_ok;

	slrf_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.touch_count (touch_count),
		.end_count   (end_count),
		.cell_cfg    (cell_cfg)
	);

	// The chain moves whenever the result register is free or being emptied.
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	always_comb begin
		chain_item[0]          = '0;
		chain_item[0].label    = s_axis_tdata[LABEL_BITS-1:0];
		chain_item[0].in_image = s_axis_tuser[0];
		chain_item[0].first    = s_axis_tuser[1];
		chain_item[0].last     = s_axis_tlast;
	end
	assign chain_valid[0] = s_axis_tvalid;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		slrf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.ccfg      (cell_cfg[k]),
			.in_valid  (chain_valid[k]),
			.in_item   (chain_item[k]),
			.out_valid (chain_valid[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	assign tail         = chain_item[NUM_CELLS];
	assign tail_ends_ok = (tail.ecnt == end_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_valid[NUM_CELLS] && tail.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keep_q    <= !tail.fhit && tail_ends_ok && (tail.tcnt == touch_count);
			fhit_q    <= tail.fhit;
			ends_ok_q <= tail_ends_ok;
			tcnt_q    <= tail.tcnt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, tcnt_q, ends_ok_q, fhit_q, keep_q};

	a_keep_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[0] || (!m_axis_tdata[1] && m_axis_tdata[2])))
		else $error("keep set with forbidden hit or bad endings");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[6:3] <= TCNT_W'(MAX_TOUCH)))
		else $error("touched count above list size");

	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> $stable(chain_valid[NUM_CELLS:1]))
		else $error("chain moved while result stalled");

endmodule

// ===== test/tb_streamline_label_roi_filter_core.sv =====
// Self-checking testbench for streamline_label_roi_filter_core: directed fibers,
// then randomized fiber streams under several list setups, checked by a scoreboard.
// Depends on slrf_pkg and the RTL of the core; needs no files or arguments.
module tb_streamline_label_roi_filter_core;
	timeunit 1ns;
	timeprecision 1ps;
	import slrf_pkg::*;

	typedef struct packed {
		logic       keep;
		logic       forbidden_hit;
		logic       endings_ok;
		logic [3:0] touched_count;
	} fiber_verdict_t;

	typedef struct packed {
		logic [63:0] touch_lo;
		logic [63:0] touch_hi;
		logic [63:0] forbid_lo;
		logic [63:0] forbid_hi;
		logic [63:0] end_lbl;
		logic [3:0]  touch_cnt;
		logic [3:0]  forbid_cnt;
		logic [2:0]  end_cnt;
	} filter_cfg_t;

	typedef enum int {
		STYLE_RANDOM,
		STYLE_FULL,
		STYLE_EMPTY,
		STYLE_OVER,
		STYLE_ONES
	} cfg_style_t;

	// Tracks the per-fiber seen bits and queues the verdict of every finished fiber.
	class fiber_verdict_model;
		logic [63:0] touch_lo, touch_hi, forbid_lo, forbid_hi, end_lbl;
		logic [3:0]  touch_cnt, forbid_cnt;
		logic [2:0]  end_cnt;
		logic [7:0]  touch_seen;
		logic [3:0]  end_seen;
		logic        forbid_flag;
		fiber_verdict_t pending[$];
		int errors;

		function new();
			touch_lo = '0;
			touch_hi = '0;
			forbid_lo = '0;
			forbid_hi = '0;
			end_lbl = '0;
			touch_cnt = '0;
			forbid_cnt = '0;
			end_cnt = '0;
			touch_seen = '0;
			end_seen = '0;
			forbid_flag = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [63:0] value);
			case (idx)
				CFG_TOUCH_LO:   touch_lo = value;
				CFG_TOUCH_HI:   touch_hi = value;
				CFG_TOUCH_CNT:  touch_cnt = value[3:0];
				CFG_FORBID_LO:  forbid_lo = value;
				CFG_FORBID_HI:  forbid_hi = value;
				CFG_FORBID_CNT: forbid_cnt = value[3:0];
				CFG_END_LBL:    end_lbl = value;
				CFG_END_CNT:    end_cnt = value[2:0];
				default: ;
			endcase
		endfunction

		// Index of the first entry in use that equals the label, or -1.
		function int first_hit(logic [63:0] lo, logic [63:0] hi, int count, int limit,
				logic [15:0] lbl);
			int n;
			n = (count < limit) ? count : limit;
			for (int k = 0; k < n; k++)
				if (lbl == 16'(((k < 4) ? lo : hi) >> (16 * (k % 4))))
					return k;
			return -1;
		endfunction

		function void take_point(logic [15:0] lbl, logic in_image, logic first, logic last);
			int m;
			fiber_verdict_t v;
			if (first) begin
				touch_seen = '0;
				end_seen = '0;
				forbid_flag = 1'b0;
			end
			if (in_image) begin
				if (first || last) begin
					m = first_hit(end_lbl, end_lbl, int'(end_cnt), MAX_ENDS, lbl);
					if (m >= 0)
						end_seen[m] = 1'b1;
				end
				m = first_hit(forbid_lo, forbid_hi, int'(forbid_cnt), MAX_FORBID, lbl);
				if (m >= 0)
					forbid_flag = 1'b1;
				m = first_hit(touch_lo, touch_hi, int'(touch_cnt), MAX_TOUCH, lbl);
				if (m >= 0)
					touch_seen[m] = 1'b1;
			end
			if (last) begin
				v.touched_count = 4'($countones(touch_seen));
				v.endings_ok = ($countones(end_seen) == int'(end_cnt));
				v.forbidden_hit = forbid_flag;
				v.keep = !forbid_flag && v.endings_ok && (v.touched_count == touch_cnt);
				pending = {pending, v};
				touch_seen = '0;
				end_seen = '0;
				forbid_flag = 1'b0;
			end
		endfunction

		function void check_verdict(logic [7:0] data);
			fiber_verdict_t want;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, data);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[0] !== want.keep) begin
				$display("%0t: keep expected %0d actual %0d", $time, want.keep, data[0]);
				errors++;
			end
			if (data[1] !== want.forbidden_hit) begin
				$display("%0t: forbidden_hit expected %0d actual %0d", $time,
					want.forbidden_hit, data[1]);
				errors++;
			end
			if (data[2] !== want.endings_ok) begin
				$display("%0t: endings_ok expected %0d actual %0d", $time,
					want.endings_ok, data[2]);
				errors++;
			end
			if (data[6:3] !== want.touched_count) begin
				$display("%0t: touched_count expected %0d actual %0d", $time,
					want.touched_count, data[6:3]);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fiber_verdict_model verdicts;
	int points_sent;
	int holds_asked;
	logic tx_steady;
	logic rx_steady;

	streamline_label_roi_filter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				verdicts.take_point(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				verdicts.check_verdict(m_axis_tdata);
		end
	end

	// Result side: random back-pressure or steady acceptance, plus long holds asked for by the stimulus.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (rx_steady)
				m_axis_tready = 1'b1;
			else
				m_axis_tready = ($urandom_range(99) >= 25);
		end
	end

	task automatic send_point(logic [15:0] lbl, logic in_image, logic first, logic last);
		@(negedge clk);
		while (!tx_steady && $urandom_range(99) < 25) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = lbl;
		s_axis_tuser = {first, in_image};
		s_axis_tlast = last;
		do @(posedge clk); while (!s_axis_tready);
		points_sent++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		verdicts.write_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_config(filter_cfg_t c);
		write_reg(CFG_TOUCH_LO, c.touch_lo);
		write_reg(CFG_TOUCH_HI, c.touch_hi);
		write_reg(CFG_TOUCH_CNT, 64'(c.touch_cnt));
		write_reg(CFG_FORBID_LO, c.forbid_lo);
		write_reg(CFG_FORBID_HI, c.forbid_hi);
		write_reg(CFG_FORBID_CNT, 64'(c.forbid_cnt));
		write_reg(CFG_END_LBL, c.end_lbl);
		write_reg(CFG_END_CNT, 64'(c.end_cnt));
	endtask

	// Waits for every verdict, then for points that make none to leave the chain.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (verdicts.outstanding() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	function automatic logic [63:0] pool_word(logic [15:0] pool [10]);
		logic [63:0] w;
		for (int i = 0; i < 4; i++)
			w[16 * i +: 16] = pool[$urandom_range(9)];
		return w;
	endfunction

	task automatic random_config(cfg_style_t style, output filter_cfg_t c);
		logic [15:0] pool [10];
		pool[0] = 16'h0000;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < 10; i++)
			pool[i] = 16'($urandom);
		// A small shared pool gives duplicates and labels common to several lists.
		c.touch_lo = pool_word(pool);
		c.touch_hi = pool_word(pool);
		c.forbid_lo = pool_word(pool);
		c.forbid_hi = pool_word(pool);
		c.end_lbl = pool_word(pool);
		c.touch_cnt = 4'($urandom_range(8));
		c.forbid_cnt = 4'($urandom_range(8));
		c.end_cnt = 3'($urandom_range(4));
		case (style)
			STYLE_FULL: begin
				c.touch_cnt = 4'd8;
				c.forbid_cnt = 4'd8;
				c.end_cnt = 3'd4;
			end
			STYLE_EMPTY: begin
				c.touch_lo = {$urandom, $urandom};
				c.forbid_hi = {$urandom, $urandom};
				c.touch_cnt = 4'd0;
				c.forbid_cnt = 4'd0;
				c.end_cnt = 3'd0;
			end
			STYLE_OVER: begin
				c.touch_cnt = 4'($urandom_range(15, 9));
				c.forbid_cnt = 4'($urandom_range(15, 9));
				c.end_cnt = 3'($urandom_range(7, 5));
			end
			STYLE_ONES: begin
				c.touch_lo = '1;
				c.touch_hi = '1;
				c.forbid_lo = '1;
				c.forbid_hi = '1;
				c.end_lbl = '1;
			end
			default: ;
		endcase
	endtask

	// Labels mostly come from the lists so that matches are frequent.
	function automatic logic [15:0] pick_label(filter_cfg_t c, logic at_end);
		int k;
		logic [63:0] w;
		if (at_end && $urandom_range(1))
			return c.end_lbl[16 * $urandom_range(3) +: 16];
		k = $urandom_range(27);
		if (k >= 20)
			return 16'($urandom);
		case (k / 4)
			0: w = c.touch_lo;
			1: w = c.touch_hi;
			2: w = c.forbid_lo;
			3: w = c.forbid_hi;
			default: w = c.end_lbl;
		endcase
		return w[16 * (k % 4) +: 16];
	endfunction

	function automatic logic point_in_image();
		return $urandom_range(99) < 90;
	endfunction

	task automatic send_fiber(filter_cfg_t c);
		int kind;
		int mids;
		kind = $urandom_range(99);
		if (kind < 12)
			send_point(pick_label(c, 1'b1), point_in_image(), 1'b1, 1'b1);
		else if (kind < 85) begin
			mids = $urandom_range(8);
			send_point(pick_label(c, 1'b1), point_in_image(), 1'b1, 1'b0);
			repeat (mids) send_point(pick_label(c, 1'b0), point_in_image(), 1'b0, 1'b0);
			send_point(pick_label(c, 1'b1), point_in_image(), 1'b0, 1'b1);
		end else begin
			// Broken runs: stray marks, missing ends, repeated first points.
			mids = $urandom_range(6, 1);
			repeat (mids) send_point(pick_label(c, 1'b0), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		filter_cfg_t c;
		int phase;
		int phase_end;
		cfg_style_t style;
		verdicts = new();
		points_sent = 0;
		holds_asked = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With the lists empty after reset, a one-point fiber is kept.
		send_point(16'h0000, 1'b1, 1'b1, 1'b1);
		settle();

		c = '0;
		c.touch_lo = {16'h0000, 16'h1234, 16'hFFFF, 16'h0000};
		c.touch_hi = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		c.touch_cnt = 4'd3;
		c.forbid_lo = {16'h0000, 16'h0000, 16'h0000, 16'hDEAD};
		c.forbid_cnt = 4'd1;
		c.end_lbl = {16'h0000, 16'h0000, 16'h0002, 16'h0001};
		c.end_cnt = 3'd2;
		apply_config(c);
		// Fiber meeting every condition, with an outside point on a forbidden label.
		send_point(16'h0001, 1'b1, 1'b1, 1'b0);
		send_point(16'h0000, 1'b1, 1'b0, 1'b0);
		send_point(16'hFFFF, 1'b1, 1'b0, 1'b0);
		send_point(16'h1234, 1'b1, 1'b0, 1'b0);
		send_point(16'hDEAD, 1'b0, 1'b0, 1'b0);
		send_point(16'h0002, 1'b1, 1'b0, 1'b1);
		// Touch labels after a forbidden one are still counted.
		send_point(16'h0001, 1'b1, 1'b1, 1'b0);
		send_point(16'hDEAD, 1'b1, 1'b0, 1'b0);
		send_point(16'h0000, 1'b1, 1'b0, 1'b0);
		send_point(16'h0002, 1'b1, 1'b0, 1'b1);
		// Last point outside the image still closes the fiber.
		send_point(16'h0001, 1'b1, 1'b1, 1'b0);
		send_point(16'h0002, 1'b0, 1'b0, 1'b1);
		// Unfinished fiber dropped by the next first point.
		send_point(16'h0001, 1'b1, 1'b1, 1'b0);
		send_point(16'h0000, 1'b1, 1'b0, 1'b0);
		send_point(16'h0001, 1'b1, 1'b1, 1'b1);
		// An ending label in the middle of a fiber does not count.
		send_point(16'h0002, 1'b1, 1'b1, 1'b0);
		send_point(16'h0001, 1'b1, 1'b0, 1'b0);
		send_point(16'h0003, 1'b1, 1'b0, 1'b1);
		settle();

		// Duplicated entries and counts above the list sizes.
		c.touch_lo = '0;
		c.touch_hi = '0;
		c.touch_cnt = 4'd15;
		c.forbid_lo = {16'hBEEF, 16'hBEEF, 16'hBEEF, 16'hBEEF};
		c.forbid_cnt = 4'd9;
		c.end_lbl = '0;
		c.end_cnt = 3'd7;
		apply_config(c);
		send_point(16'h0000, 1'b1, 1'b1, 1'b0);
		send_point(16'h0000, 1'b1, 1'b0, 1'b1);
		send_point(16'h0000, 1'b1, 1'b0, 1'b1);
		send_point(16'hBEEF, 1'b1, 1'b0, 1'b0);
		settle();

		phase = 0;
		while (points_sent < 1620) begin
			case (phase % 6)
				0: style = STYLE_FULL;
				1: style = STYLE_EMPTY;
				2: style = STYLE_OVER;
				4: style = STYLE_ONES;
				default: style = STYLE_RANDOM;
			endcase
			random_config(style, c);
			apply_config(c);
			if (phase == 3)
				holds_asked++;
			tx_steady = (phase == 5);
			rx_steady = (phase == 5);
			phase_end = points_sent + 160;
			while (points_sent < phase_end)
				send_fiber(c);
			settle();
			phase++;
		end

		repeat (20) @(negedge clk);
		if (verdicts.errors == 0)
			$display("streamline_label_roi_filter_core regression: pass");
		else
			$display("streamline_label_roi_filter_core regression: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("streamline_label_roi_filter_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/slrf_pkg.sv
rtl/slrf_cfg.sv
rtl/slrf_cell.sv
rtl/streamline_label_roi_filter_core.sv
test/tb_streamline_label_roi_filter_core.sv
